FILE: sv/vector3_normalize_unit_macros.svh
// Assertion macros shared by the vector normalise RTL.
`ifndef VECTOR3_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR3_NORMALIZE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define VNU_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VNU_ASSERT(lbl, prop, msg) `VNU_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)
`else
`define VNU_ASSERT_CR(lbl, clk, rstn, prop, msg)
`define VNU_ASSERT(lbl, prop, msg)
`endif
`endif

FILE: sv/vnu_pkg.sv
// Shared constants and types of the vector normalise unit.
`default_nettype none
package vnu_pkg;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned UNIT_W = 32;
  localparam int unsigned THR_W  = 32;
  localparam int unsigned OUT_DATA_W = LEN_W + 3 * UNIT_W;
  localparam logic [LEN_W-1:0]  LEN_MAX  = 32'hFFFF_FFFF;
  localparam logic [UNIT_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
  localparam logic [UNIT_W-1:0] SAT_NEG  = 32'h8000_0000;
  localparam logic [THR_W-1:0]  THR_RESET = 32'h0000_0001;

  typedef struct packed {
    logic kill;     // no division result: zero flag or zero length
    logic is_zero;
  } vnu_flags_t;
endpackage
`default_nettype wire

FILE: sv/vnu_square.sv
// Magnitude split and sum of squares, three register stages.
`default_nettype none
module vnu_square #(
  parameter int unsigned CW = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [3*CW-1:0]   comp_i,
  output logic                   valid_o,
  output logic [2*CW-1:0]        sum_o,
  output logic [3*CW-1:0]        mag_o,
  output logic [2:0]             neg_o
);
  localparam int unsigned K  = (CW + 1) / 2;
  localparam int unsigned H  = CW - K;
  localparam int unsigned SW = 2 * CW;

  logic [CW-1:0]    mag_d [3];
  logic [2:0]       neg_d;
  logic [2*H-1:0]   hh_d [3];
  logic [H+K-1:0]   hl_d [3];
  logic [2*K-1:0]   ll_d [3];

  logic             v1_q, v2_q, v3_q;
  logic [CW-1:0]    mag1_q [3];
  logic [CW-1:0]    mag2_q [3];
  logic [CW-1:0]    mag3_q [3];
  logic [2:0]       neg1_q, neg2_q, neg3_q;
  logic [2*H-1:0]   hh1_q [3];
  logic [H+K-1:0]   hl1_q [3];
  logic [2*K-1:0]   ll1_q [3];
  logic [SW-1:0]    sq_d [3];
  logic [SW-1:0]    sq2_q [3];
  logic [SW-1:0]    sum3_q;

  // halves keep each product within a narrow multiplier
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = comp_i[i*CW + CW - 1];
      mag_d[i] = neg_d[i] ? (~comp_i[i*CW +: CW] + 1'b1) : comp_i[i*CW +: CW];
      hh_d[i]  = mag_d[i][CW-1:K] * mag_d[i][CW-1:K];
      hl_d[i]  = mag_d[i][CW-1:K] * mag_d[i][K-1:0];
      ll_d[i]  = mag_d[i][K-1:0] * mag_d[i][K-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = (SW'(hh1_q[i]) << (2 * K)) + (SW'(hl1_q[i]) << (K + 1)) + SW'(ll1_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q <= mag_d;
      neg1_q <= neg_d;
      hh1_q  <= hh_d;
      hl1_q  <= hl_d;
      ll1_q  <= ll_d;
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      sq2_q  <= sq_d;
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
      sum3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
    end
  end

  assign valid_o = v3_q;
  assign sum_o   = sum3_q;
  assign neg_o   = neg3_q;
  assign mag_o   = {mag3_q[2], mag3_q[1], mag3_q[0]};
endmodule
`default_nettype wire

FILE: sv/vnu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module vnu_sqrt #(
  parameter int unsigned CW     = 32,
  parameter int unsigned SIDE_W = 99
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [2*CW-1:0]   rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [CW-1:0]          root_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int unsigned RW = CW + 2;

  logic              v_q    [CW];
  logic [2*CW-1:0]   rad_q  [CW];
  logic [RW-1:0]     rem_q  [CW];
  logic [CW-1:0]     root_q [CW];
  logic [SIDE_W-1:0] side_q [CW];

  for (genvar s = 0; s < CW; s++) begin : g_stage
    logic              v_p;
    logic [2*CW-1:0]   rad_p;
    logic [RW-1:0]     rem_p;
    logic [CW-1:0]     root_p;
    logic [SIDE_W-1:0] side_p;
    logic [RW-1:0]     rem_t, trial, rem_n;
    logic [CW-1:0]     root_n;

    if (s == 0) begin : g_first
      assign v_p    = valid_i;
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[s-1];
      assign rad_p  = rad_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign side_p = side_q[s-1];
    end

    always_comb begin
      rem_t = {rem_p[RW-3:0], rad_p[2*CW-1 -: 2]};
      trial = {root_p, 2'b01};
      if (rem_t >= trial) begin
        rem_n  = rem_t - trial;
        root_n = {root_p[CW-2:0], 1'b1};
      end else begin
        rem_n  = rem_t;
        root_n = {root_p[CW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= rad_p << 2;
        rem_q[s]  <= rem_n;
        root_q[s] <= root_n;
        side_q[s] <= side_p;
      end
    end
  end

  assign valid_o = v_q[CW-1];
  assign root_o  = root_q[CW-1];
  assign side_o  = side_q[CW-1];
endmodule
`default_nettype wire

FILE: sv/vnu_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module vnu_div #(
  parameter int unsigned CW     = 32,
  parameter int unsigned U      = 30,
  parameter int unsigned SIDE_W = 37
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [CW-1:0]     len_i,
  input  wire logic [3*CW-1:0]   mag_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [3*(U+1)-1:0]     q_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int unsigned QW = U + 1;

  logic              v_q    [QW];
  logic [CW-1:0]     len_q  [QW];
  logic [CW-1:0]     rem_q  [QW][3];
  logic [QW-1:0]     q_q    [QW][3];
  logic [SIDE_W-1:0] side_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic              v_p;
    logic [CW-1:0]     len_p;
    logic [CW-1:0]     rem_p [3];
    logic [QW-1:0]     q_p   [3];
    logic [2:0]        nbit;
    logic [SIDE_W-1:0] side_p;
    logic [CW:0]       rem_t [3];
    logic [CW-1:0]     rem_n [3];
    logic [QW-1:0]     q_n   [3];

    if (j == 0) begin : g_first
      // mag <= len, so the quotient starts at bit U with mag >> 1 as remainder
      assign v_p    = valid_i;
      assign len_p  = len_i;
      assign side_p = side_i;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_p[i] = {1'b0, mag_i[i*CW+1 +: CW-1]};
        assign q_p[i]   = '0;
        assign nbit[i]  = mag_i[i*CW];
      end
    end else begin : g_next
      assign v_p    = v_q[j-1];
      assign len_p  = len_q[j-1];
      assign side_p = side_q[j-1];
      assign rem_p  = rem_q[j-1];
      assign q_p    = q_q[j-1];
      assign nbit   = '0;
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_t[i] = {rem_p[i], nbit[i]};
        if (rem_t[i] >= {1'b0, len_p}) begin
          rem_n[i] = CW'(rem_t[i] - {1'b0, len_p});
          q_n[i]   = {q_p[i][QW-2:0], 1'b1};
        end else begin
          rem_n[i] = rem_t[i][CW-1:0];
          q_n[i]   = {q_p[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[j]  <= len_p;
        rem_q[j]  <= rem_n;
        q_q[j]    <= q_n;
        side_q[j] <= side_p;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign q_o     = {q_q[QW-1][2], q_q[QW-1][1], q_q[QW-1][0]};
  assign side_o  = side_q[QW-1];
endmodule
`default_nettype wire

FILE: sv/vector3_normalize_unit.sv
// Pipeline: squaring stages, root stages, divider stages and an output register.
// Throughput: one vector per cycle; the squaring, root and divider stages all move
// on one shared enable, which holds only while a result sits unclaimed in the output register.
// Reset clears every valid bit and sets the zero threshold to 1; data registers are not reset.
`default_nettype none
`include "vector3_normalize_unit_macros.svh"
module vector3_normalize_unit #(
  parameter int unsigned COMPONENT_WIDTH    = 32,
  parameter int unsigned UNIT_FRACTION_BITS = 30
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // vec_x, vec_y, vec_z, zero padding to whole bytes
  input  wire logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // length, unit_x, unit_y, unit_z
  output logic [vnu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // is_zero
  output logic [0:0]               m_axis_tuser,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [vnu_pkg::THR_W-1:0] cfg_data_i
);
  localparam int unsigned CW     = COMPONENT_WIDTH;
  localparam int unsigned QW     = UNIT_FRACTION_BITS + 1;
  localparam int unsigned ZW     = (CW > vnu_pkg::LEN_W) ? CW : vnu_pkg::LEN_W;
  localparam int unsigned CMP_W  = (QW > 33) ? QW : 33;
  localparam int unsigned SQ_SIDE = 3 * CW + 3;
  localparam int unsigned DV_SIDE = 3 + 2 + vnu_pkg::LEN_W;

  logic                    en;
  logic [vnu_pkg::THR_W-1:0] thr_q;

  logic                    sq_valid;
  logic [2*CW-1:0]         sq_sum;
  logic [3*CW-1:0]         sq_mag;
  logic [2:0]              sq_neg;

  logic                    rt_valid;
  logic [CW-1:0]           rt_root;
  logic [SQ_SIDE-1:0]      rt_side;

  vnu_pkg::vnu_flags_t     flags_d;
  logic [vnu_pkg::LEN_W-1:0] len_sat;

  logic                    dv_valid;
  logic [3*QW-1:0]         dv_q;
  logic [DV_SIDE-1:0]      dv_side;
  vnu_pkg::vnu_flags_t     dv_flags;
  logic [2:0]              dv_neg;

  logic                    out_v_q;
  logic [vnu_pkg::LEN_W-1:0]  len_q;
  logic                    zero_q;
  logic [vnu_pkg::UNIT_W-1:0] unit_d [3];
  logic [vnu_pkg::UNIT_W-1:0] unit_q [3];

  function automatic logic [vnu_pkg::UNIT_W-1:0] to_signed(input logic neg,
                                                           input logic [QW-1:0] q);
    logic [CMP_W-1:0] qe;
    qe = CMP_W'(q);
    if (!neg) begin
      to_signed = (qe > CMP_W'(vnu_pkg::SAT_POS)) ? vnu_pkg::SAT_POS : qe[vnu_pkg::UNIT_W-1:0];
    end else if (qe >= CMP_W'(vnu_pkg::SAT_NEG)) begin
      to_signed = vnu_pkg::SAT_NEG;
    end else begin
      to_signed = ~qe[vnu_pkg::UNIT_W-1:0] + 1'b1;
    end
  endfunction

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= vnu_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  vnu_square #(.CW(CW)) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .comp_i  (s_axis_tdata[3*CW-1:0]),
    .valid_o (sq_valid),
    .sum_o   (sq_sum),
    .mag_o   (sq_mag),
    .neg_o   (sq_neg)
  );

  vnu_sqrt #(.CW(CW), .SIDE_W(SQ_SIDE)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .rad_i   (sq_sum),
    .side_i  ({sq_neg, sq_mag}),
    .valid_o (rt_valid),
    .root_o  (rt_root),
    .side_o  (rt_side)
  );

  // threshold compares the unsaturated length
  always_comb begin
    flags_d.is_zero = ZW'(rt_root) < ZW'(thr_q);
    flags_d.kill    = flags_d.is_zero || (rt_root == '0);
    len_sat = (ZW'(rt_root) > ZW'(vnu_pkg::LEN_MAX)) ? vnu_pkg::LEN_MAX
                                                      : vnu_pkg::LEN_W'(ZW'(rt_root));
  end

  vnu_div #(.CW(CW), .U(UNIT_FRACTION_BITS), .SIDE_W(DV_SIDE)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_valid),
    .len_i   (rt_root),
    .mag_i   (rt_side[3*CW-1:0]),
    .side_i  ({rt_side[SQ_SIDE-1 -: 3], flags_d, len_sat}),
    .valid_o (dv_valid),
    .q_o     (dv_q),
    .side_o  (dv_side)
  );

  assign dv_neg   = dv_side[DV_SIDE-1 -: 3];
  assign dv_flags = dv_side[vnu_pkg::LEN_W +: 2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_d[i] = dv_flags.kill ? '0 : to_signed(dv_neg[i], dv_q[i*QW +: QW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q  <= dv_side[vnu_pkg::LEN_W-1:0];
      zero_q <= dv_flags.is_zero;
      unit_q <= unit_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {unit_q[2], unit_q[1], unit_q[0], len_q};
  assign m_axis_tuser  = zero_q;

  `VNU_ASSERT(a_zero_gives_null, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[vnu_pkg::OUT_DATA_W-1:vnu_pkg::LEN_W] == '0, "zero flag with nonzero unit vector")
  `VNU_ASSERT(a_nil_len_null, m_axis_tvalid && (m_axis_tdata[vnu_pkg::LEN_W-1:0] == '0) |-> m_axis_tdata[vnu_pkg::OUT_DATA_W-1:vnu_pkg::LEN_W] == '0, "zero length with nonzero unit vector")
  `VNU_ASSERT(a_stall_holds_root, !en |=> $stable(rt_root) && $stable(rt_valid) && $stable(dv_q), "pipeline moved during stall")
endmodule
`default_nettype wire

FILE: dv/vector3_normalize_unit_tb.sv
// Self-checking testbench for the vector normalise unit: stream driver, monitor and predictor.
`default_nettype none
module vector3_normalize_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = 32;
  localparam int unsigned UFB = 30;
  localparam int unsigned LATENCY = CW + UFB + 5;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [CW-1:0] z;
    logic [CW-1:0] y;
    logic [CW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic [31:0] len;
    logic        is_zero;
  } norm_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [((3*CW+7)/8)*8-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [vnu_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [vnu_pkg::THR_W-1:0] cfg_data_i = '0;

  vector3_normalize_unit #(.COMPONENT_WIDTH(CW), .UNIT_FRACTION_BITS(UFB)) DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [31:0] thr_model;
  vec_t  pending_vecs[$];
  norm_t expected_norms[$];
  int    errors = 0;
  int    n_results = 0;
  int    n_zero = 0;
  bit    calm = 1'b0;     // no idling in the last part
  bit    hold_req = 1'b0; // long receiver stall requested
  int    hold_left = 0;   // receiver stall cycles still to go
  int    idle_cycles = 0;
  bit    timed_out = 1'b0;

  function automatic logic [63:0] isqrt96(logic [95:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= {32'd0, n}) r = c;
    end
    return r;
  endfunction

  function automatic norm_t predict_norm(vec_t v, logic [31:0] thr);
    norm_t o;
    logic [CW-1:0] comp[3];
    logic [CW:0] mag[3];
    logic [95:0] sumsq;
    logic [63:0] len;
    logic [127:0] q;
    comp[0] = v.x; comp[1] = v.y; comp[2] = v.z;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][CW-1] ? ({1'b0, ~comp[i]} + 1'b1) : {1'b0, comp[i]};
      sumsq += {63'd0, mag[i]} * {63'd0, mag[i]};
    end
    len = isqrt96(sumsq);
    o.len = (len > 64'hFFFF_FFFF) ? vnu_pkg::LEN_MAX : len[31:0];
    o.is_zero = len < {32'd0, thr};
    for (int i = 0; i < 3; i++) begin
      logic [31:0] u;
      if (o.is_zero || len == 0) u = '0;
      else begin
        q = ({95'd0, mag[i]} << UFB) / {64'd0, len};
        if (!comp[i][CW-1]) u = (q > 128'h7FFF_FFFF) ? vnu_pkg::SAT_POS : q[31:0];
        else u = (q >= 128'h8000_0000) ? vnu_pkg::SAT_NEG : (~q[31:0] + 1'b1);
      end
      if (i == 0) o.ux = u; else if (i == 1) o.uy = u; else o.uz = u;
    end
    return o;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_norms.push_back(predict_norm(vec_t'(s_axis_tdata), thr_model));
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_vecs.size() > 0) begin
          s_axis_tdata <= pending_vecs.pop_front();
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 13);
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        norm_t got;
        norm_t exp_n;
        got.len = m_axis_tdata[31:0];
        got.ux = m_axis_tdata[63:32];
        got.uy = m_axis_tdata[95:64];
        got.uz = m_axis_tdata[127:96];
        got.is_zero = m_axis_tuser[0];
        n_results++;
        if (got.is_zero) n_zero++;
        if (expected_norms.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_n = expected_norms.pop_front();
          if (got.len !== exp_n.len) begin
            $error("length exp %h got %h", exp_n.len, got.len); errors++;
          end
          if (got.is_zero !== exp_n.is_zero) begin
            $error("is_zero exp %b got %b", exp_n.is_zero, got.is_zero); errors++;
          end
          if (got.ux !== exp_n.ux) begin
            $error("unit_x exp %h got %h", exp_n.ux, got.ux); errors++;
          end
          if (got.uy !== exp_n.uy) begin
            $error("unit_y exp %h got %h", exp_n.uy, got.uy); errors++;
          end
          if (got.uz !== exp_n.uz) begin
            $error("unit_z exp %h got %h", exp_n.uz, got.uz); errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_left <= LATENCY * 3;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 15) == 0) recv_gap <= $urandom_range(1, 13);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o) || hold_req || hold_left > 0)
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) timed_out = 1'b1;
    end
  end

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 7) - 3;
      3: return $urandom_range(0, 4095) - 2048;
      4: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while ((pending_vecs.size() > 0 || s_axis_tvalid || expected_norms.size() > 0)
           && !timed_out)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [31:0] thr);
    cfg_data_i <= thr;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    thr_model = thr;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_vec(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    vec_t v;
    v.x = x; v.y = y; v.z = z;
    pending_vecs.push_back(v);
  endtask

  task automatic run_phase();
    @(posedge clk_i);
    wait_drained();
    if (timed_out) begin
      $display("vector3_normalize_unit_tb NOT OK");
      $finish;
    end
  endtask

  initial begin
    logic [31:0] thr_set[6];
    thr_model = vnu_pkg::THR_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset threshold
    queue_vec(0, 0, 0);
    queue_vec(1, 0, 0);
    queue_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_vec(32'h8000_0000, 0, 0);
    queue_vec(0, 32'h7FFF_FFFF, 0);
    queue_vec(0, 0, 32'hFFFF_FFFF);
    queue_vec(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
    queue_vec(3, 4, 0);
    queue_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
    run_phase();

    // zero length with threshold 0: no flag, zero vector
    write_threshold(0);
    queue_vec(0, 0, 0);
    queue_vec(32'h8000_0000, 1, 32'h7FFF_FFFF);
    run_phase();
    write_threshold(32'hFFFF_FFFF);
    queue_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_vec(32'h0100_0000, 0, 0);
    run_phase();

    // random phases across threshold settings
    thr_set = '{1, 0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0800, 32'h0100_0000};
    for (int p = 0; p < 6; p++) begin
      write_threshold(p == 5 ? $urandom : thr_set[p]);
      if (p == 5) calm = 1'b1;
      for (int i = 0; i < 270; i++) queue_vec(rand_comp(), rand_comp(), rand_comp());
      if (p == 2) begin
        // receiver holds off long enough for the pipe to back up
        hold_req = 1'b1;
        while (hold_left == 0) @(posedge clk_i);
        hold_req = 1'b0;
        while (hold_left > 0) @(posedge clk_i);
      end
      run_phase();
    end

    $display("vectors: %0d results checked, %0d flagged zero", n_results, n_zero);
    $display("thresholds swept 0, 1, max and mid values, with back-pressure");
    if (errors == 0 && expected_norms.size() == 0)
      $display("vector3_normalize_unit_tb OK");
    else
      $display("vector3_normalize_unit_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
